// ----- hw/rtl/gwvu_pkg.sv -----
// Shared types, widths and codes for the gravity well velocity update block.
`timescale 1ns / 1ps
package gwvu_pkg;

  localparam int POS_W       = 32;
  localparam int MAG_W       = POS_W + 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int ROOT_W      = MAG_W;
  localparam int DEN_W       = 3 * MAG_W;
  localparam int MASS_W      = 32;
  localparam int LIM_W       = 31;
  localparam int MS_W        = 16;
  localparam int DV_W        = LIM_W + MS_W;
  localparam int MS_PER_S    = 1000;
  localparam int KREM_W      = 10;
  localparam int VSUM_W      = DV_W + 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [LIM_W-1:0] FORCE_LIMIT_RST = LIM_W'(65536);
  localparam logic [PADDR_W-3:0] REG_FORCE_LIMIT = '0;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WELL = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] start_vel_x;
    logic signed [31:0] start_vel_y;
    logic signed [31:0] start_vel_z;
    logic [31:0]        well_mass;
    logic [15:0]        elapsed_ms;
  } req_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               well_skipped;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT,
    ST_CUBE1,
    ST_CUBE2,
    ST_MULM,
    ST_DIV,
    ST_MULT,
    ST_DIVK,
    ST_UPD,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/gravity_well_velocity_update.sv -----
// Top level of the gravity well velocity update block.
`timescale 1ns / 1ps
// One request is taken at a time; a new request is taken while the previous
// result still waits downstream. A load request skips all arithmetic. A well
// request runs through one shared shift-and-add multiplier, a serial square
// root and two restoring dividers, one bit per cycle; the bit-serial force
// division per axis is the longest step. The finished result waits while
// downstream stalls.
// A well at zero distance finishes after the square root.
module gravity_well_velocity_update
  import gwvu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int NUM_W = MAG_W + MASS_W + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  state_t state, state_next;

  logic [LIM_W-1:0]  force_limit;
  logic [POS_W-1:0]  obj [3];
  logic [POS_W-1:0]  vel [3];
  logic [MS_W-1:0]   step_ms;
  logic [MAG_W-1:0]  mag [3];
  logic [2:0]        neg;
  logic [MASS_W-1:0] mass;
  logic [1:0]        comp;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  mcand;
  logic [MAG_W-1:0]  mplier;
  logic [DEN_W-1:0]  acc;
  logic [DEN_W-1:0]  acc_add;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  numsr;
  logic [DEN_W-1:0]  rem;
  logic [31:0]       q;
  logic              ovf;
  logic [DV_W-1:0]   kdiv;
  logic [KREM_W-1:0] krem;
  logic              skipped;

  logic              accept;
  logic              last;
  logic              cfg_wr;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] distance;

  logic [MAG_W-1:0]  d_full [3];
  logic [MAG_W-1:0]  mag_in [3];
  logic [DEN_W:0]    r2;
  logic              div_ge;
  logic [DEN_W:0]    div_diff;
  logic [31:0]       q_n;
  logic              ovf_n;
  logic [LIM_W-1:0]  f;
  logic [KREM_W:0]   k2;
  logic              k_ge;
  logic [KREM_W:0]   k_diff;
  logic [VSUM_W-1:0] vext;
  logic [VSUM_W-1:0] dvext;
  logic [VSUM_W-1:0] vsum;
  logic [POS_W-1:0]  vsat;
  logic [POS_W-1:0]  well [3];

  gwvu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (acc[SQ_W-1:0]),
    .root     (distance),
    .done     (sqrt_done)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_FORCE_LIMIT);
  assign prdata = (paddr[PADDR_W-1:2] == REG_FORCE_LIMIT) ? PDATA_W'(force_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_limit <= FORCE_LIMIT_RST;
    end else if (cfg_wr) begin
      force_limit <= pwdata[LIM_W-1:0];
    end
  end

  assign accept = req_valid && !req_stall;
  assign last   = (cnt == CNT_W'(1));

  always_comb begin
    well[0] = req.pos_x;
    well[1] = req.pos_y;
    well[2] = req.pos_z;
    for (int i = 0; i < 3; i++) begin
      d_full[i] = {well[i][POS_W-1], well[i]} - {obj[i][POS_W-1], obj[i]};
      mag_in[i] = d_full[i][MAG_W-1] ? (MAG_W'(0) - d_full[i]) : d_full[i];
    end
  end

  always_comb begin
    acc_add  = acc + (mplier[0] ? mcand : '0);
    r2       = {rem, numsr[NUM_W-1]};
    div_ge   = (r2 >= {1'b0, den});
    div_diff = r2 - {1'b0, den};
    q_n      = {q[30:0], div_ge};
    ovf_n    = ovf | q[31];
    f        = (ovf_n || (q_n > {1'b0, force_limit})) ? force_limit : q_n[LIM_W-1:0];
    k2       = {krem, kdiv[DV_W-1]};
    k_ge     = (k2 >= (KREM_W + 1)'(MS_PER_S));
    k_diff   = k2 - (KREM_W + 1)'(MS_PER_S);
    vext     = {{(VSUM_W - POS_W){vel[comp][POS_W-1]}}, vel[comp]};
    dvext    = {2'b00, kdiv};
    vsum     = neg[comp] ? (vext - dvext) : (vext + dvext);
    if (!vsum[VSUM_W-1] && (vsum[VSUM_W-2:POS_W-1] != '0)) begin
      vsat = {1'b0, {(POS_W - 1){1'b1}}};
    end else if (vsum[VSUM_W-1] && (vsum[VSUM_W-2:POS_W-1] != '1)) begin
      vsat = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      vsat = vsum[POS_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.cmd == CMD_LOAD) ? ST_DONE : ST_SQ;
        end
      end
      ST_SQ:      if (last && comp == 2'd2) state_next = ST_SQRT_GO;
      ST_SQRT_GO: state_next = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_next = (distance == '0) ? ST_DONE : ST_CUBE1;
        end
      end
      ST_CUBE1:   if (last) state_next = ST_CUBE2;
      ST_CUBE2:   if (last) state_next = ST_MULM;
      ST_MULM:    if (last) state_next = ST_DIV;
      ST_DIV:     if (last) state_next = ST_MULT;
      ST_MULT:    if (last) state_next = ST_DIVK;
      ST_DIVK:    if (last) state_next = ST_UPD;
      ST_UPD:     state_next = (comp == 2'd2) ? ST_DONE : ST_MULM;
      ST_DONE:    if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = (state != ST_IDLE);
    sqrt_start = (state == ST_SQRT_GO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        obj[i] <= '0;
        vel[i] <= '0;
      end
      step_ms <= '0;
      comp    <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (state != ST_DONE && rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && req.cmd == CMD_LOAD) begin
            obj[0]  <= req.pos_x;
            obj[1]  <= req.pos_y;
            obj[2]  <= req.pos_z;
            vel[0]  <= req.start_vel_x;
            vel[1]  <= req.start_vel_y;
            vel[2]  <= req.start_vel_z;
            step_ms <= req.elapsed_ms;
          end
          comp <= '0;
          cnt  <= CNT_W'(MAG_W);
        end
        ST_SQ: begin
          cnt <= last ? CNT_W'(MAG_W) : cnt - CNT_W'(1);
          if (last) comp <= comp + 2'd1;
        end
        ST_SQRT: cnt <= CNT_W'(ROOT_W);
        ST_CUBE1: cnt <= last ? CNT_W'(ROOT_W) : cnt - CNT_W'(1);
        ST_CUBE2: begin
          cnt <= last ? CNT_W'(MASS_W) : cnt - CNT_W'(1);
          if (last) comp <= '0;
        end
        ST_MULM: cnt <= last ? CNT_W'(NUM_W) : cnt - CNT_W'(1);
        ST_DIV:  cnt <= last ? CNT_W'(MS_W) : cnt - CNT_W'(1);
        ST_MULT: cnt <= last ? CNT_W'(DV_W) : cnt - CNT_W'(1);
        ST_DIVK: cnt <= cnt - CNT_W'(1);
        ST_UPD: begin
          vel[comp] <= vsat;
          comp      <= comp + 2'd1;
          cnt       <= CNT_W'(MASS_W);
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) rsp_valid <= 1'b1;
        end
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        skipped <= 1'b0;
        if (accept && req.cmd == CMD_WELL) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag_in[i];
            neg[i] <= d_full[i][MAG_W-1];
          end
          mass   <= req.well_mass;
          mcand  <= DEN_W'(mag_in[0]);
          mplier <= mag_in[0];
          acc    <= '0;
        end
      end
      ST_SQ: begin
        acc <= acc_add;
        if (last) begin
          if (comp != 2'd2) begin
            mcand  <= DEN_W'(mag[comp + 2'd1]);
            mplier <= mag[comp + 2'd1];
          end
        end else begin
          mcand  <= {mcand[DEN_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MAG_W-1:1]};
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          skipped <= (distance == '0);
          mcand   <= DEN_W'(distance);
          mplier  <= distance;
          acc     <= '0;
        end
      end
      ST_CUBE1: begin
        if (last) begin
          mcand  <= DEN_W'(acc_add[SQ_W-1:0]);
          mplier <= distance;
          acc    <= '0;
        end else begin
          acc    <= acc_add;
          mcand  <= {mcand[DEN_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MAG_W-1:1]};
        end
      end
      ST_CUBE2: begin
        if (last) begin
          den    <= acc_add;
          mcand  <= DEN_W'(mag[0]);
          mplier <= MAG_W'(mass);
          acc    <= '0;
        end else begin
          acc    <= acc_add;
          mcand  <= {mcand[DEN_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MAG_W-1:1]};
        end
      end
      ST_MULM: begin
        if (last) begin
          numsr <= {acc_add[MAG_W+MASS_W-1:0], {(2 * FRAC_BITS){1'b0}}};
          rem   <= '0;
          q     <= '0;
          ovf   <= 1'b0;
        end else begin
          acc    <= acc_add;
          mcand  <= {mcand[DEN_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MAG_W-1:1]};
        end
      end
      ST_DIV: begin
        rem   <= div_ge ? div_diff[DEN_W-1:0] : r2[DEN_W-1:0];
        q     <= q_n;
        ovf   <= ovf_n;
        numsr <= {numsr[NUM_W-2:0], 1'b0};
        if (last) begin
          mcand  <= DEN_W'(f);
          mplier <= MAG_W'(step_ms);
          acc    <= '0;
        end
      end
      ST_MULT: begin
        if (last) begin
          kdiv <= acc_add[DV_W-1:0];
          krem <= '0;
        end else begin
          acc    <= acc_add;
          mcand  <= {mcand[DEN_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MAG_W-1:1]};
        end
      end
      ST_DIVK: begin
        krem <= k_ge ? k_diff[KREM_W-1:0] : k2[KREM_W-1:0];
        kdiv <= {kdiv[DV_W-2:0], k_ge};
      end
      ST_UPD: begin
        if (comp != 2'd2) begin
          mcand  <= DEN_W'(mag[comp + 2'd1]);
          mplier <= MAG_W'(mass);
          acc    <= '0;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp.vel_x        <= vel[0];
          rsp.vel_y        <= vel[1];
          rsp.vel_z        <= vel[2];
          rsp.well_skipped <= skipped;
        end
      end
      default: acc <= acc;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted request did not start work");

  a_root_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_SQRT)
    else $error("square root finished outside its wait state");

  a_axis_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD || state == ST_DIV) |-> comp != 2'd3)
    else $error("axis index out of range");
`endif

endmodule

// ----- hw/rtl/gwvu_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module gwvu_sqrt
  import gwvu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   sr;
  logic [ROOT_W:0]   rem;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [ROOT_W+2:0] r2;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              ge;

  always_comb begin
    r2    = {rem, sr[SQ_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    ge    = (r2 >= trial);
    diff  = r2 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      sr   <= {sr[SQ_W-3:0], 2'b00};
      rem  <= ge ? diff[ROOT_W:0] : r2[ROOT_W:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule
